>>> rtl/tbc_pkg.sv
// ----------------------------------------------------------------------------
// tbc_pkg
// Shared types and codes for the countdown timer bank: request and status
// codes, the command and response words, and the layout of one slot entry.
// ----------------------------------------------------------------------------
package tbc_pkg;

    localparam int TIMER_SLOTS_DEFAULT = 16;
    localparam int ID_W                = 8;
    localparam int CNT_W               = 32;
    localparam int MAX_RESULTS         = 16;
    localparam int NREP_W              = $clog2(MAX_RESULTS + 1);

    // request codes
    localparam logic [2:0] REQ_REGISTER = 3'd0;
    localparam logic [2:0] REQ_REMOVE   = 3'd1;
    localparam logic [2:0] REQ_START    = 3'd2;
    localparam logic [2:0] REQ_STOP     = 3'd3;
    localparam logic [2:0] REQ_PERIOD   = 3'd4;
    localparam logic [2:0] REQ_MODE     = 3'd5;
    localparam logic [2:0] REQ_ENABLE   = 3'd6;
    localparam logic [2:0] REQ_TICK     = 3'd7;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_DUP  = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    typedef struct packed {
        logic [2:0]       req_type;
        logic [ID_W-1:0]  timer_id;
        logic [CNT_W-1:0] argument;
        logic             cyclic;
    } cmd_word_t;

    typedef struct packed {
        logic [1:0]      status;
        logic            expired;
        logic [ID_W-1:0] expired_id;
        logic            last;
    } rsp_word_t;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [CNT_W-1:0] period;
        logic [CNT_W-1:0] count;
        logic             cyclic;
        logic             enabled;
    } slot_entry_t;

    localparam int ENTRY_W = $bits(slot_entry_t);

    typedef struct packed {
        logic match;   // slot holds the requested id
        logic write;   // entry changed, write back
        logic expire;  // tick expiry on this slot
    } slot_outcome_t;

endpackage

>>> rtl/tbc_ram.sv
// ----------------------------------------------------------------------------
// tbc_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module tbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/tbc_slot_alu.sv
// ----------------------------------------------------------------------------
// tbc_slot_alu
// Read-modify logic for one slot entry: applies a command to the slot that
// holds the requested id, or advances the countdown on a tick.
// ----------------------------------------------------------------------------
module tbc_slot_alu (
    input  tbc_pkg::cmd_word_t     req,
    input  logic                   slot_valid,
    input  tbc_pkg::slot_entry_t   entry,
    output tbc_pkg::slot_entry_t   entry_new,
    output tbc_pkg::slot_entry_t   fresh,
    output tbc_pkg::slot_outcome_t outcome
);

    logic is_tick;
    logic active;

    assign is_tick = (req.req_type == tbc_pkg::REQ_TICK);
    assign active  = slot_valid && entry.enabled;

    // entry written on a successful register
    always_comb
    begin
        fresh.id      = req.timer_id;
        fresh.period  = req.argument;
        fresh.count   = '0;
        fresh.cyclic  = req.cyclic;
        fresh.enabled = 1'b0;
    end

    always_comb
    begin
        entry_new      = entry;
        outcome.match  = 1'b0;
        outcome.write  = 1'b0;
        outcome.expire = 1'b0;
        if (is_tick)
        begin
            if (active)
            begin
                outcome.write = 1'b1;
                if (entry.count != '0)
                begin
                    entry_new.count = entry.count - 1'b1;
                end
                else
                begin
                    outcome.expire = 1'b1;
                    // reload or drop out
                    if (entry.cyclic)
                    begin
                        entry_new.count = entry.period;
                    end
                    else
                    begin
                        entry_new.enabled = 1'b0;
                    end
                end
            end
        end
        else if (slot_valid && (req.timer_id != '0) && (entry.id == req.timer_id))
        begin
            outcome.match = 1'b1;
            case (req.req_type)
                tbc_pkg::REQ_START:
                begin
                    outcome.write     = 1'b1;
                    entry_new.count   = entry.period;
                    entry_new.enabled = 1'b1;
                end
                tbc_pkg::REQ_STOP:
                begin
                    outcome.write     = 1'b1;
                    entry_new.enabled = 1'b0;
                end
                tbc_pkg::REQ_PERIOD:
                begin
                    outcome.write    = 1'b1;
                    entry_new.count  = '0;
                    entry_new.period = req.argument;
                end
                tbc_pkg::REQ_MODE:
                begin
                    outcome.write    = 1'b1;
                    entry_new.cyclic = req.argument[0];
                end
                tbc_pkg::REQ_ENABLE:
                begin
                    outcome.write     = 1'b1;
                    entry_new.enabled = req.argument[0];
                end
                default:
                begin
                    // register (duplicate) and remove leave the entry alone
                    outcome.write = 1'b0;
                end
            endcase
        end
    end

endmodule

>>> rtl/timer_bank_countdown_unit.sv
// ----------------------------------------------------------------------------
// timer_bank_countdown_unit
// Bank of countdown timers held in a slot RAM, driven by commands and ticks.
// ----------------------------------------------------------------------------
// Every command word and every tick walks all TIMER_SLOTS slots of the slot
// RAM, one slot per cycle through its single read port while the response
// side does not stall. A word is accepted in the idle state, walked slot by
// slot in the walk state and closed in the finish state. Commands
// give one response word; a tick gives one word per expired timer in slot
// order (at most 16, the final one marked last) or one plain word if nothing
// expired. Valid bits sit in flip-flops and clear at reset; the RAM needs no
// clearing pass. The next command is taken while the last response waits.
// ----------------------------------------------------------------------------
module timer_bank_countdown_unit #(
    parameter int TIMER_SLOTS = tbc_pkg::TIMER_SLOTS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  tbc_pkg::cmd_word_t cmd,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output tbc_pkg::rsp_word_t rsp
);

    localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(TIMER_SLOTS - 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_WALK   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0]                  state_reg, state_next;
    tbc_pkg::cmd_word_t          req_reg, req_next;
    logic [IDX_W-1:0]            pos_reg, pos_next;
    logic [TIMER_SLOTS-1:0]      valid_reg, valid_next;
    logic                        found_reg, found_next;
    logic                        hold_valid_reg, hold_valid_next;
    logic [tbc_pkg::ID_W-1:0]    hold_id_reg, hold_id_next;
    logic [tbc_pkg::NREP_W-1:0]  nrep_reg, nrep_next;
    tbc_pkg::rsp_word_t          rsp_reg, rsp_next;
    logic                        rsp_valid_reg, rsp_valid_next;

    logic                        ram_we;
    logic [IDX_W-1:0]            ram_waddr;
    logic [tbc_pkg::ENTRY_W-1:0] ram_wdata;
    logic [IDX_W-1:0]            ram_raddr;
    logic [tbc_pkg::ENTRY_W-1:0] ram_rdata;

    tbc_pkg::slot_entry_t        entry;
    tbc_pkg::slot_entry_t        entry_new;
    tbc_pkg::slot_entry_t        fresh;
    tbc_pkg::slot_outcome_t      outcome;

    logic                        rsp_free;
    logic                        rsp_load;
    tbc_pkg::rsp_word_t          rsp_word;
    logic                        has_free;
    logic [IDX_W-1:0]            free_idx;
    logic [1:0]                  cmd_status;

    tbc_ram #(
        .WIDTH (tbc_pkg::ENTRY_W),
        .DEPTH (TIMER_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign entry = tbc_pkg::slot_entry_t'(ram_rdata);

    tbc_slot_alu u_slot_alu (
        .req        (req_reg),
        .slot_valid (valid_reg[pos_reg]),
        .entry      (entry),
        .entry_new  (entry_new),
        .fresh      (fresh),
        .outcome    (outcome)
    );

    // lowest free slot
    always_comb
    begin
        has_free = 1'b0;
        free_idx = '0;
        for (int i = TIMER_SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                has_free = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        if (req_reg.req_type == tbc_pkg::REQ_REGISTER)
        begin
            if ((req_reg.timer_id == '0) || (req_reg.argument == '0))
            begin
                cmd_status = tbc_pkg::ST_BAD;
            end
            else if (found_reg)
            begin
                cmd_status = tbc_pkg::ST_DUP;
            end
            else if (!has_free)
            begin
                cmd_status = tbc_pkg::ST_FULL;
            end
            else
            begin
                cmd_status = tbc_pkg::ST_OK;
            end
        end
        else
        begin
            cmd_status = found_reg ? tbc_pkg::ST_OK : tbc_pkg::ST_BAD;
        end
    end

    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign cmd_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        pos_next        = pos_reg;
        valid_next      = valid_reg;
        found_next      = found_reg;
        hold_valid_next = hold_valid_reg;
        hold_id_next    = hold_id_reg;
        nrep_next       = nrep_reg;
        ram_we          = 1'b0;
        ram_waddr       = pos_reg;
        ram_wdata       = entry_new;
        ram_raddr       = pos_reg;
        rsp_load        = 1'b0;
        rsp_word        = '0;

        case (state_reg)
            S_IDLE:
            begin
                ram_raddr = '0;
                if (cmd_valid)
                begin
                    req_next        = cmd;
                    pos_next        = '0;
                    found_next      = 1'b0;
                    hold_valid_next = 1'b0;
                    nrep_next       = '0;
                    state_next      = S_WALK;
                end
            end
            S_WALK:
            begin
                // hold the read address while the response side is blocked
                if (rsp_free)
                begin
                    ram_raddr = IDX_W'(pos_reg + 1'b1);
                    ram_we    = outcome.write;
                    if (outcome.match)
                    begin
                        found_next = 1'b1;
                        if (req_reg.req_type == tbc_pkg::REQ_REMOVE)
                        begin
                            valid_next[pos_reg] = 1'b0;
                        end
                    end
                    if (outcome.expire && (nrep_reg < tbc_pkg::NREP_W'(tbc_pkg::MAX_RESULTS)))
                    begin
                        // a newer expiry means the held one is not last
                        if (hold_valid_reg)
                        begin
                            rsp_load            = 1'b1;
                            rsp_word.status     = tbc_pkg::ST_OK;
                            rsp_word.expired    = 1'b1;
                            rsp_word.expired_id = hold_id_reg;
                            rsp_word.last       = 1'b0;
                        end
                        hold_valid_next = 1'b1;
                        hold_id_next    = entry.id;
                        nrep_next       = nrep_reg + 1'b1;
                    end
                    if (pos_reg == LAST_POS)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        pos_next = IDX_W'(pos_reg + 1'b1);
                    end
                end
            end
            S_FINISH:
            begin
                if (rsp_free)
                begin
                    rsp_load      = 1'b1;
                    rsp_word.last = 1'b1;
                    state_next    = S_IDLE;
                    if (req_reg.req_type == tbc_pkg::REQ_TICK)
                    begin
                        rsp_word.status = tbc_pkg::ST_OK;
                        if (hold_valid_reg)
                        begin
                            rsp_word.expired    = 1'b1;
                            rsp_word.expired_id = hold_id_reg;
                        end
                    end
                    else
                    begin
                        rsp_word.status = cmd_status;
                        if ((req_reg.req_type == tbc_pkg::REQ_REGISTER) &&
                            (cmd_status == tbc_pkg::ST_OK))
                        begin
                            ram_we               = 1'b1;
                            ram_waddr            = free_idx;
                            ram_wdata            = fresh;
                            valid_next[free_idx] = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_next       = rsp_word;
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            found_reg      <= 1'b0;
            hold_valid_reg <= 1'b0;
            nrep_reg       <= '0;
            rsp_valid_reg  <= 1'b0;
            pos_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            found_reg      <= found_next;
            hold_valid_reg <= hold_valid_next;
            nrep_reg       <= nrep_next;
            rsp_valid_reg  <= rsp_valid_next;
            pos_reg        <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        hold_id_reg <= hold_id_next;
        rsp_reg     <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> tb/timer_bank_countdown_unit_tb.sv
// ----------------------------------------------------------------------------
// timer_bank_countdown_unit_tb
// Self-checking regression for the countdown timer bank. Command and tick
// words are sent through the valid/stall input. Each accepted word runs
// through a slot-table predictor that queues the response words it must cause.
// Every accepted response word is checked field by field against the oldest
// queued word. Stimulus covers zero ids, zero periods, duplicates, a full
// table, a tick where all sixteen timers expire, and random command mixes.
// Idle and stall patterns change between phases, and one long hold-off on
// the response side backs the block up.
// ----------------------------------------------------------------------------
module timer_bank_countdown_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TIMER_SLOTS = tbc_pkg::TIMER_SLOTS_DEFAULT;
    localparam int HOLD_CYCLES = 400;
    localparam int POOL_SIZE   = 20;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cmd_valid = 1'b0;
    logic               cmd_stall;
    tbc_pkg::cmd_word_t cmd       = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    tbc_pkg::rsp_word_t rsp;

    // predicted slot table
    bit                      tm_valid   [TIMER_SLOTS];
    bit [tbc_pkg::ID_W-1:0]  tm_id      [TIMER_SLOTS];
    bit [tbc_pkg::CNT_W-1:0] tm_period  [TIMER_SLOTS];
    bit [tbc_pkg::CNT_W-1:0] tm_count   [TIMER_SLOTS];
    bit                      tm_cyclic  [TIMER_SLOTS];
    bit                      tm_enabled [TIMER_SLOTS];

    tbc_pkg::rsp_word_t      expected_rsp_q [$];
    int                      fail_count    = 0;
    int                      tx_idle_pct   = 0;
    int                      rx_idle_pct   = 0;
    int                      hold_requests = 0;
    int                      hold_served   = 0;
    int                      hold_left     = 0;
    bit [tbc_pkg::ID_W-1:0]  id_pool [POOL_SIZE];

    timer_bank_countdown_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    initial
    begin
        #(5_000_000);
        $display("timer_bank_countdown_unit regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor: apply one accepted word to the table, queue its responses
    // ------------------------------------------------------------------------
    function automatic void predict_response(input tbc_pkg::cmd_word_t c);
        int                     slot;
        int                     free_slot;
        logic [1:0]             st;
        bit [tbc_pkg::ID_W-1:0] fired [$];
        tbc_pkg::rsp_word_t     r;

        if (c.req_type == tbc_pkg::REQ_TICK)
        begin
            for (int i = 0; i < TIMER_SLOTS; i++)
            begin
                if (tm_valid[i] && tm_enabled[i])
                begin
                    if (tm_count[i] != 0)
                    begin
                        tm_count[i] = tm_count[i] - 1;
                    end
                    else
                    begin
                        if (tm_cyclic[i])
                        begin
                            tm_count[i] = tm_period[i];
                        end
                        else
                        begin
                            tm_enabled[i] = 1'b0;
                        end
                        if (fired.size() < tbc_pkg::MAX_RESULTS)
                        begin
                            fired.push_back(tm_id[i]);
                        end
                    end
                end
            end
            if (fired.size() == 0)
            begin
                r = '{status: tbc_pkg::ST_OK, expired: 1'b0, expired_id: '0, last: 1'b1};
                expected_rsp_q.push_back(r);
            end
            for (int k = 0; k < fired.size(); k++)
            begin
                r = '{status: tbc_pkg::ST_OK, expired: 1'b1, expired_id: fired[k],
                      last: (k == fired.size() - 1)};
                expected_rsp_q.push_back(r);
            end
            return;
        end

        slot = -1;
        free_slot = -1;
        for (int i = TIMER_SLOTS - 1; i >= 0; i--)
        begin
            if (c.timer_id != 0 && tm_valid[i] && tm_id[i] == c.timer_id)
            begin
                slot = i;
            end
            if (!tm_valid[i])
            begin
                free_slot = i;
            end
        end

        st = tbc_pkg::ST_OK;
        if (c.req_type == tbc_pkg::REQ_REGISTER)
        begin
            if (c.timer_id == 0 || c.argument == 0)
            begin
                st = tbc_pkg::ST_BAD;
            end
            else if (slot >= 0)
            begin
                st = tbc_pkg::ST_DUP;
            end
            else if (free_slot < 0)
            begin
                st = tbc_pkg::ST_FULL;
            end
            else
            begin
                tm_valid[free_slot]   = 1'b1;
                tm_id[free_slot]      = c.timer_id;
                tm_period[free_slot]  = c.argument;
                tm_count[free_slot]   = '0;
                tm_cyclic[free_slot]  = c.cyclic;
                tm_enabled[free_slot] = 1'b0;
            end
        end
        else if (slot < 0)
        begin
            st = tbc_pkg::ST_BAD;
        end
        else
        begin
            case (c.req_type)
                tbc_pkg::REQ_REMOVE:
                begin
                    tm_valid[slot]   = 1'b0;
                    tm_enabled[slot] = 1'b0;
                end
                tbc_pkg::REQ_START:
                begin
                    tm_count[slot]   = tm_period[slot];
                    tm_enabled[slot] = 1'b1;
                end
                tbc_pkg::REQ_STOP:
                begin
                    tm_enabled[slot] = 1'b0;
                end
                tbc_pkg::REQ_PERIOD:
                begin
                    tm_count[slot]  = '0;
                    tm_period[slot] = c.argument;
                end
                tbc_pkg::REQ_MODE:
                begin
                    tm_cyclic[slot] = c.argument[0];
                end
                default:
                begin
                    tm_enabled[slot] = c.argument[0];
                end
            endcase
        end
        r = '{status: st, expired: 1'b0, expired_id: '0, last: 1'b1};
        expected_rsp_q.push_back(r);
    endfunction

    // ------------------------------------------------------------------------
    // Response checker
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_rsp
        tbc_pkg::rsp_word_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsp_q.size() == 0)
            begin
                $display("%0t: unexpected response word: status %0d expired %0d id %0d last %0d",
                         $time, rsp.status, rsp.expired, rsp.expired_id, rsp.last);
                fail_count++;
            end
            else
            begin
                want = expected_rsp_q.pop_front();
                if (rsp.status !== want.status)
                begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, rsp.status);
                    fail_count++;
                end
                if (rsp.expired !== want.expired)
                begin
                    $display("%0t: expired mismatch: expected %0d, actual %0d",
                             $time, want.expired, rsp.expired);
                    fail_count++;
                end
                if (rsp.expired_id !== want.expired_id)
                begin
                    $display("%0t: expired_id mismatch: expected %0d, actual %0d",
                             $time, want.expired_id, rsp.expired_id);
                    fail_count++;
                end
                if (rsp.last !== want.last)
                begin
                    $display("%0t: last mismatch: expected %0d, actual %0d",
                             $time, want.last, rsp.last);
                    fail_count++;
                end
            end
        end
    end

    // Response side: random stall, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            rsp_stall   <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else
        begin
            rsp_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Word helpers
    // ------------------------------------------------------------------------
    function automatic tbc_pkg::cmd_word_t make_cmd(input logic [2:0] req,
                                                    input logic [tbc_pkg::ID_W-1:0] id,
                                                    input logic [tbc_pkg::CNT_W-1:0] arg,
                                                    input logic cyc);
        tbc_pkg::cmd_word_t c;
        c.req_type = req;
        c.timer_id = id;
        c.argument = arg;
        c.cyclic   = cyc;
        return c;
    endfunction

    // Keep valid high across back-to-back words; drop it only for a gap.
    task automatic send_word(input tbc_pkg::cmd_word_t word);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= word;
        @(posedge clk);
        while (cmd_stall)
        begin
            @(posedge clk);
        end
        predict_response(word);
    endtask

    task automatic wait_drain();
        cmd_valid <= 1'b0;
        while (expected_rsp_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic tbc_pkg::cmd_word_t random_cmd();
        int                      pick;
        logic [2:0]              req;
        logic [tbc_pkg::ID_W-1:0]  id;
        logic [tbc_pkg::CNT_W-1:0] arg;
        pick = $urandom_range(99);
        if (pick < 35)
        begin
            req = tbc_pkg::REQ_TICK;
        end
        else if (pick < 50)
        begin
            req = tbc_pkg::REQ_REGISTER;
        end
        else if (pick < 62)
        begin
            req = tbc_pkg::REQ_START;
        end
        else if (pick < 70)
        begin
            req = tbc_pkg::REQ_STOP;
        end
        else if (pick < 78)
        begin
            req = tbc_pkg::REQ_PERIOD;
        end
        else if (pick < 85)
        begin
            req = tbc_pkg::REQ_MODE;
        end
        else if (pick < 93)
        begin
            req = tbc_pkg::REQ_ENABLE;
        end
        else
        begin
            req = tbc_pkg::REQ_REMOVE;
        end
        id = ($urandom_range(99) < 3) ? '0 : id_pool[$urandom_range(POOL_SIZE - 1)];
        // short periods so timers actually fire; sometimes a full-width value
        if ((req == tbc_pkg::REQ_REGISTER || req == tbc_pkg::REQ_PERIOD) &&
            $urandom_range(99) < 80)
        begin
            arg = $urandom_range(6);
        end
        else
        begin
            arg = $urandom();
        end
        return make_cmd(req, id, arg, 1'($urandom_range(1)));
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_zero_id();
        for (int r = tbc_pkg::REQ_REGISTER; r < tbc_pkg::REQ_TICK; r++)
        begin
            send_word(make_cmd(3'(r), '0, 32'd5, 1'b1));
        end
    endtask

    task automatic test_lifecycle();
        send_word(make_cmd(tbc_pkg::REQ_REGISTER, 8'd255, 32'd0, 1'b0));
        send_word(make_cmd(tbc_pkg::REQ_REGISTER, 8'd1, 32'd1, 1'b1));
        send_word(make_cmd(tbc_pkg::REQ_REGISTER, 8'd1, 32'd7, 1'b0));
        send_word(make_cmd(tbc_pkg::REQ_REGISTER, 8'd255, 32'hFFFF_FFFF, 1'b0));
        send_word(make_cmd(tbc_pkg::REQ_START, 8'd1, 32'hFFFF_FFFF, 1'b0));
        send_word(make_cmd(tbc_pkg::REQ_TICK, 8'hAA, 32'h5555_AAAA, 1'b1));
        send_word(make_cmd(tbc_pkg::REQ_TICK, 8'h55, 32'hAAAA_5555, 1'b0));
        send_word(make_cmd(tbc_pkg::REQ_TICK, '0, '0, 1'b0));
        send_word(make_cmd(tbc_pkg::REQ_REMOVE, 8'd77, '0, 1'b0));
        // mode takes bit 0 only: this makes timer 1 one-shot
        send_word(make_cmd(tbc_pkg::REQ_MODE, 8'd1, 32'hFFFF_FFFE, 1'b1));
        send_word(make_cmd(tbc_pkg::REQ_PERIOD, 8'd255, 32'd0, 1'b0));
        send_word(make_cmd(tbc_pkg::REQ_ENABLE, 8'd255, 32'h0000_0001, 1'b0));
        send_word(make_cmd(tbc_pkg::REQ_TICK, 8'hFF, 32'hFFFF_FFFF, 1'b1));
        send_word(make_cmd(tbc_pkg::REQ_TICK, '0, '0, 1'b0));
        send_word(make_cmd(tbc_pkg::REQ_STOP, 8'd1, '0, 1'b0));
        send_word(make_cmd(tbc_pkg::REQ_REMOVE, 8'd255, '0, 1'b0));
        send_word(make_cmd(tbc_pkg::REQ_REMOVE, 8'd255, '0, 1'b0));
        send_word(make_cmd(tbc_pkg::REQ_REMOVE, 8'd1, '0, 1'b0));
    endtask

    // Fill every slot, overflow, then enable all so one tick fires them all.
    task automatic test_table_fill();
        bit [tbc_pkg::ID_W-1:0] ids [TIMER_SLOTS + 1];
        bit                     clash;
        for (int i = 0; i <= TIMER_SLOTS; i++)
        begin
            do
            begin
                ids[i] = 8'($urandom_range(1, 255));
                clash = 1'b0;
                for (int j = 0; j < i; j++)
                begin
                    if (ids[j] == ids[i])
                    begin
                        clash = 1'b1;
                    end
                end
            end while (clash);
        end
        for (int i = 0; i < TIMER_SLOTS; i++)
        begin
            send_word(make_cmd(tbc_pkg::REQ_REGISTER, ids[i], $urandom_range(1, 3),
                               1'($urandom_range(1))));
        end
        send_word(make_cmd(tbc_pkg::REQ_REGISTER, ids[TIMER_SLOTS], 32'd2, 1'b1));
        send_word(make_cmd(tbc_pkg::REQ_REGISTER, ids[0], 32'd2, 1'b1));
        for (int i = 0; i < TIMER_SLOTS; i++)
        begin
            send_word(make_cmd(tbc_pkg::REQ_ENABLE, ids[i], $urandom() | 32'h1, 1'b0));
        end
        repeat (6) send_word(make_cmd(tbc_pkg::REQ_TICK, 8'($urandom()), $urandom(),
                                      1'($urandom_range(1))));
        for (int i = 0; i < TIMER_SLOTS; i++)
        begin
            send_word(make_cmd(tbc_pkg::REQ_REMOVE, ids[i], $urandom(),
                               1'($urandom_range(1))));
        end
    endtask

    task automatic run_random(input int count);
        repeat (count) send_word(random_cmd());
    endtask

    // Stall the response side long enough for the block to back up its input.
    task automatic test_backpressure();
        hold_requests <= hold_requests + 1;
        run_random(30);
    endtask

    initial
    begin
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            id_pool[i] = 8'($urandom_range(1, 255));
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        tx_idle_pct = 11;
        rx_idle_pct = 55;
        test_zero_id();
        test_lifecycle();
        test_table_fill();
        run_random(35);
        wait_drain();

        tx_idle_pct = 55;
        rx_idle_pct = 11;
        run_random(35);
        test_backpressure();
        wait_drain();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(30);
        wait_drain();

        repeat (40) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("timer_bank_countdown_unit regression: pass");
        end
        else
        begin
            $display("timer_bank_countdown_unit regression: fail");
        end
        $finish;
    end

endmodule
